@@ src/ldtwr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldtwr_pkg
// Shared types and constants for the two-wire LED driver refresh transmitter.
// ----------------------------------------------------------------------------
package ldtwr_pkg;

  // Default display buffer depth
  localparam int unsigned BUFFER_BYTES_DEF = 16;

  // Field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAME_W   = 2;
  localparam int unsigned BITPOS_W  = 3;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CMD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_CMD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_CMD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 2'd3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0]  DATA_CMD_RST   = 8'h40;
  localparam logic [BYTE_W-1:0]  ADDR_CMD_RST   = 8'hC0;
  localparam logic [BYTE_W-1:0]  BRIGHT_CMD_RST = 8'h8F;
  localparam logic [COUNT_W-1:0] BYTE_COUNT_RST = 5'd12;

  // Frame numbers
  localparam logic [FRAME_W-1:0] FRAME_DATA   = 2'd0;
  localparam logic [FRAME_W-1:0] FRAME_ADDR   = 2'd1;
  localparam logic [FRAME_W-1:0] FRAME_BRIGHT = 2'd2;

  // Pin sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START1,
    PH_START2,
    PH_BIT1,
    PH_BIT2,
    PH_BIT3,
    PH_STOP1,
    PH_STOP2,
    PH_STOP3,
    PH_STOP4
  } phase_t;

  // One result item
  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy_res;
    logic sequence_done;
  } result_t;

endpackage

@@ src/led_driver_two_wire_refresh.sv @@
// ----------------------------------------------------------------------------
// led_driver_two_wire_refresh
// Pin-level write transmitter for a two-wire LED driver: display buffer in a
// synchronous RAM, a phase sequencer for start / byte / stop framing.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | in_valid/in_stall  | mode, write_index, write_value
//  output   | out       | out_valid/out_stall| clock_pin, data_pin, busy_res,
//           |           |                    | sequence_done
//  config   | in        | cfg_write_en       | cfg_index, cfg_data
//
//  One item per clock unless in_stall is high; each result is registered in
//  the output register or the skid entry. A tick loading the next buffer byte
//  reads the RAM; the read register feeds it to the shift register before the
//  bit phase that needs it. in_stall rises only when both the output register
//  and the skid entry hold. Reset is synchronous; the buffer reads as zero
//  through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module led_driver_two_wire_refresh #(
  parameter int unsigned BUFFER_BYTES = ldtwr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ldtwr_pkg::MODE_W-1:0]     mode,
  input  logic [ldtwr_pkg::INDEX_W-1:0]    write_index,
  input  logic [ldtwr_pkg::BYTE_W-1:0]     write_value,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             clock_pin,
  output logic                             data_pin,
  output logic                             busy_res,
  output logic                             sequence_done,
  // configuration
  input  logic                             cfg_write_en,
  input  logic [ldtwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldtwr_pkg::BYTE_W-1:0]     cfg_data
);
  import ldtwr_pkg::*;

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(BUFFER_BYTES);

  // Configuration registers
  logic [BYTE_W-1:0]  data_cmd;
  logic [BYTE_W-1:0]  addr_cmd;
  logic [BYTE_W-1:0]  bright_cmd;
  logic [COUNT_W-1:0] byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_cmd   <= DATA_CMD_RST;
      addr_cmd   <= ADDR_CMD_RST;
      bright_cmd <= BRIGHT_CMD_RST;
      byte_count <= BYTE_COUNT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_DATA_CMD:   data_cmd   <= cfg_data;
        CFG_ADDR_CMD:   addr_cmd   <= cfg_data;
        CFG_BRIGHT_CMD: bright_cmd <= cfg_data;
        CFG_BYTE_COUNT: byte_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  phase_t              phase, phase_next;
  logic [FRAME_W-1:0]  frame_num, frame_num_next;
  logic [COUNT_W-1:0]  byte_pos, byte_pos_next;
  logic [BITPOS_W-1:0] bit_pos, bit_pos_next;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  logic                clk_lvl, clk_lvl_next;
  logic                dat_lvl, dat_lvl_next;
  logic                pending, pending_next;
  logic                load_pend, load_pend_next;
  logic                done;

  // Buffer RAM control
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic                rd_hit;

  logic                in_xfer;
  logic [COUNT_W-1:0]  eff_count;
  logic [COUNT_W-1:0]  byte_pos_inc;
  logic [BYTE_W-1:0]   frame_cmd;

  assign in_xfer      = in_valid && !in_stall;
  assign eff_count    = (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
  assign byte_pos_inc = byte_pos + COUNT_W'(1);
  assign wr_addr      = write_index[AW-1:0];
  assign rd_addr      = byte_pos[AW-1:0];

  always_comb begin
    unique case (frame_num)
      FRAME_DATA: frame_cmd = data_cmd;
      FRAME_ADDR: frame_cmd = addr_cmd;
      default:    frame_cmd = bright_cmd;
    endcase
  end

  // Display buffer: one write port, one registered read port
  logic [BYTE_W-1:0]       buf_mem [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] buf_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= write_value;
    end
    if (rd_en) begin
      rd_data <= buf_mem[rd_addr];
    end
  end

  // Entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        buf_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= buf_valid[rd_addr];
      end
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      frame_num  <= '0;
      byte_pos   <= '0;
      bit_pos    <= '0;
      shift_byte <= '0;
      clk_lvl    <= 1'b1;
      dat_lvl    <= 1'b1;
      pending    <= 1'b0;
      load_pend  <= 1'b0;
    end else begin
      phase      <= phase_next;
      frame_num  <= frame_num_next;
      byte_pos   <= byte_pos_next;
      bit_pos    <= bit_pos_next;
      shift_byte <= shift_byte_next;
      clk_lvl    <= clk_lvl_next;
      dat_lvl    <= dat_lvl_next;
      pending    <= pending_next;
      load_pend  <= load_pend_next;
    end
  end

  // Item decode and phase advance
  always_comb begin
    phase_next      = phase;
    frame_num_next  = frame_num;
    byte_pos_next   = byte_pos;
    bit_pos_next    = bit_pos;
    shift_byte_next = shift_byte;
    clk_lvl_next    = clk_lvl;
    dat_lvl_next    = dat_lvl;
    pending_next    = pending;
    load_pend_next  = 1'b0;
    done            = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;

    // buffer byte read on the previous tick arrives now
    if (load_pend) begin
      shift_byte_next = rd_hit ? rd_data : '0;
    end

    if (in_xfer) begin
      unique case (mode)
        MODE_WRITE: begin
          wr_en = (32'(write_index) < BUFFER_BYTES);
        end
        MODE_REFRESH: begin
          if (phase == PH_IDLE) begin
            frame_num_next = FRAME_DATA;
            byte_pos_next  = '0;
            bit_pos_next   = '0;
            phase_next     = PH_START1;
          end else begin
            pending_next = 1'b1;
          end
        end
        MODE_TICK: begin
          unique case (phase)
            PH_IDLE: ;
            PH_START1: begin
              clk_lvl_next = 1'b1;
              dat_lvl_next = 1'b1;
              phase_next   = PH_START2;
            end
            PH_START2: begin
              dat_lvl_next    = 1'b0;
              shift_byte_next = frame_cmd;
              byte_pos_next   = '0;
              bit_pos_next    = '0;
              phase_next      = PH_BIT1;
            end
            PH_BIT1: begin
              clk_lvl_next = 1'b0;
              phase_next   = PH_BIT2;
            end
            PH_BIT2: begin
              dat_lvl_next = shift_byte[bit_pos];
              phase_next   = PH_BIT3;
            end
            PH_BIT3: begin
              clk_lvl_next = 1'b1;
              if (bit_pos != '1) begin
                bit_pos_next = bit_pos + BITPOS_W'(1);
                phase_next   = PH_BIT1;
              end else begin
                byte_pos_next = byte_pos_inc;
                bit_pos_next  = '0;
                if (frame_num == FRAME_ADDR && byte_pos_inc <= eff_count) begin
                  // fetch next segment byte; load_pend moves it into the shift register
                  rd_en          = 1'b1;
                  load_pend_next = 1'b1;
                  phase_next     = PH_BIT1;
                end else begin
                  phase_next = PH_STOP1;
                end
              end
            end
            PH_STOP1: begin
              clk_lvl_next = 1'b0;
              phase_next   = PH_STOP2;
            end
            PH_STOP2: begin
              dat_lvl_next = 1'b0;
              phase_next   = PH_STOP3;
            end
            PH_STOP3: begin
              clk_lvl_next = 1'b1;
              phase_next   = PH_STOP4;
            end
            PH_STOP4: begin
              dat_lvl_next = 1'b1;
              if (frame_num != FRAME_BRIGHT) begin
                frame_num_next = frame_num + FRAME_W'(1);
                phase_next     = PH_START1;
              end else begin
                done       = 1'b1;
                phase_next = PH_IDLE;
                // queued refresh restarts at once
                if (pending) begin
                  pending_next   = 1'b0;
                  frame_num_next = FRAME_DATA;
                  byte_pos_next  = '0;
                  bit_pos_next   = '0;
                  phase_next     = PH_START1;
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Output register with one skid entry
  result_t res_new, out_res, skid_res;
  logic    skid_valid;
  logic    out_xfer;

  assign res_new.clock_pin     = clk_lvl_next;
  assign res_new.data_pin      = dat_lvl_next;
  assign res_new.busy_res      = (phase_next != PH_IDLE);
  assign res_new.sequence_done = done;

  assign out_xfer = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_xfer) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_res <= skid_res;
      end
    end else if (in_xfer) begin
      if (out_valid && !out_xfer) begin
        skid_res <= res_new;
      end else begin
        out_res <= res_new;
      end
    end
  end

  assign clock_pin     = out_res.clock_pin;
  assign data_pin      = out_res.data_pin;
  assign busy_res      = out_res.busy_res;
  assign sequence_done = out_res.sequence_done;

endmodule

@@ src/ldtwr_chk.sv @@
// ----------------------------------------------------------------------------
// ldtwr_chk
// Port-level checks for the two-wire LED driver refresh transmitter.
// ----------------------------------------------------------------------------
module ldtwr_chk (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic clock_pin,
  input logic data_pin,
  input logic busy_res,
  input logic sequence_done
);

  // Bus is released (both lines high) whenever no refresh runs
  a_idle_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> clock_pin && data_pin)
    else $error("bus not idle-high while not busy");

  // The final stop leaves both lines high
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_done |-> clock_pin && data_pin)
    else $error("sequence ended without stop levels");

  // No result appears right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(clock_pin) && $stable(data_pin)
      && $stable(busy_res) && $stable(sequence_done))
    else $error("stalled result changed");

  // Input is held back only while a result is waiting
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind led_driver_two_wire_refresh ldtwr_chk u_ldtwr_chk (.*);
